>>> design/tzc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzc_pkg
// Shared types and constants for the triangle zero-crossing segment block.
// ----------------------------------------------------------------------------
package tzc_pkg;

    localparam int VEC_W  = 48;
    localparam int COMP_W = 16;
    localparam int BAND_W = 4;

    // one triangle
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [VEC_W-1:0]  normal_a;
        logic [VEC_W-1:0]  normal_b;
        logic [VEC_W-1:0]  normal_c;
        logic [VEC_W-1:0]  pos_a;
        logic [VEC_W-1:0]  pos_b;
        logic [VEC_W-1:0]  pos_c;
    } t_in_item;

    // one segment
    typedef struct packed {
        logic [BAND_W-1:0] out_band;
        logic [VEC_W-1:0]  end_first;
        logic [VEC_W-1:0]  end_second;
    } t_out_item;

endpackage

>>> design/triangle_zero_crossing_segment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_zero_crossing_segment
// Dots three vertex normals with the axis vector, sorts the products and
// emits the interpolated isoline segment when the zero level crosses.
// ----------------------------------------------------------------------------
// Usage: busy stays low, so a triangle is taken on every cycle that start is
// high and a segment leaves on o_strobe after it passes the pipeline (or
// never, if the triangle is not crossed or its band is out of range). The
// pipeline holds the 17-stage restoring divider that forms the edge
// weights, one quotient bit per stage, plus seven stages of multiply, sort,
// edge select and rounding. Results cannot be held off; the receiver must
// take each one. Write the axis vector only while no triangle is in flight.
module triangle_zero_crossing_segment
    import tzc_pkg::*;
#(
    parameter int BANDS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_in_item            i_item,
    output logic                o_strobe,
    output t_out_item           o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [VEC_W-1:0]    i_cfg_data
);

    localparam int P_W   = 34;   // dot product width
    localparam int D_W   = 35;   // edge denominator width
    localparam int R_W   = 52;   // divider remainder width
    localparam int Q_W   = 17;   // weight width
    localparam int DIV_N = 17;   // divider stages
    localparam int M_W   = 34;   // interpolation product width
    localparam int LATENCY = 24;

    typedef struct packed {
        logic                deg;
        logic [R_W-1:0]      rem;
        logic [P_W-1:0]      dvs;
        logic [Q_W-1:0]      quo;
        logic [VEC_W-1:0]    qlo;
        logic [VEC_W-1:0]    qhi;
    } t_div;

    // axis register
    logic [VEC_W-1:0] r_axis;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= '0;
        end else if (i_cfg_valid) begin
            r_axis <= i_cfg_data;
        end
    end

    // stage 1: nine component products
    logic                     r_v1;
    logic [BAND_W-1:0]        r_band1;
    logic signed [31:0]       r_m1 [3][3];
    logic [VEC_W-1:0]         r_q1 [3];
    logic [VEC_W-1:0]         w_nrm [3];
    logic                     w_band_ok;

    assign w_nrm[0] = i_item.normal_a;
    assign w_nrm[1] = i_item.normal_b;
    assign w_nrm[2] = i_item.normal_c;
    assign w_band_ok = {5'd0, i_item.band} < 9'(BANDS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && w_band_ok;
        end
        r_band1 <= i_item.band;
        r_q1[0] <= i_item.pos_a;
        r_q1[1] <= i_item.pos_b;
        r_q1[2] <= i_item.pos_c;
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                r_m1[v][k] <= $signed(w_nrm[v][COMP_W*k +: COMP_W])
                            * $signed(r_axis[COMP_W*k +: COMP_W]);
            end
        end
    end

    // stage 2: sum into dot products
    logic                     r_v2;
    logic [BAND_W-1:0]        r_band2;
    logic signed [P_W-1:0]    r_p2 [3];
    logic [VEC_W-1:0]         r_q2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_band2 <= r_band1;
        for (int v = 0; v < 3; v++) begin
            r_q2[v] <= r_q1[v];
            r_p2[v] <= P_W'(r_m1[v][0]) + P_W'(r_m1[v][1]) + P_W'(r_m1[v][2]);
        end
    end

    // stage 3: stable sort by rank
    logic                     r_v3;
    logic [BAND_W-1:0]        r_band3;
    logic signed [P_W-1:0]    r_p3 [3];
    logic [VEC_W-1:0]         r_q3 [3];
    logic                     w_gt_ab, w_gt_bc, w_gt_ac;
    logic [1:0]               w_rank [3];

    assign w_gt_ab = r_p2[0] > r_p2[1];
    assign w_gt_bc = r_p2[1] > r_p2[2];
    assign w_gt_ac = r_p2[0] > r_p2[2];
    assign w_rank[0] = 2'(w_gt_ab) + 2'(w_gt_ac);
    assign w_rank[1] = 2'(!w_gt_ab) + 2'(w_gt_bc);
    assign w_rank[2] = 2'(!w_gt_ac) + 2'(!w_gt_bc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_band3 <= r_band2;
        for (int r = 0; r < 3; r++) begin
            if (w_rank[0] == 2'(r)) begin
                r_p3[r] <= r_p2[0];
                r_q3[r] <= r_q2[0];
            end else if (w_rank[1] == 2'(r)) begin
                r_p3[r] <= r_p2[1];
                r_q3[r] <= r_q2[1];
            end else begin
                r_p3[r] <= r_p2[2];
                r_q3[r] <= r_q2[2];
            end
        end
    end

    // stage 4: pick crossed edges, form denominators
    logic                     r_v4;
    logic [BAND_W-1:0]        r_band4;
    logic signed [P_W-1:0]    r_phi4 [2];
    logic signed [D_W-1:0]    r_den4 [2];
    logic [VEC_W-1:0]         r_qlo4 [2];
    logic [VEC_W-1:0]         r_qhi4 [2];
    logic                     w_c01, w_c12;
    logic signed [P_W-1:0]    w_plo [2];
    logic signed [P_W-1:0]    w_phi [2];
    logic [VEC_W-1:0]         w_qlo [2];
    logic [VEC_W-1:0]         w_qhi [2];

    assign w_c01 = (r_p3[0] < 0 && r_p3[1] >= 0) || (r_p3[0] <= 0 && r_p3[1] > 0);
    assign w_c12 = (r_p3[1] < 0 && r_p3[2] >= 0) || (r_p3[1] <= 0 && r_p3[2] > 0);

    always_comb begin
        w_plo[0] = r_p3[0];
        w_qlo[0] = r_q3[0];
        w_phi[0] = w_c01 ? r_p3[1] : r_p3[2];
        w_qhi[0] = w_c01 ? r_q3[1] : r_q3[2];
        w_plo[1] = w_c01 ? r_p3[0] : r_p3[1];
        w_qlo[1] = w_c01 ? r_q3[0] : r_q3[1];
        w_phi[1] = r_p3[2];
        w_qhi[1] = r_q3[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3 && (w_c01 || w_c12);
        end
        r_band4 <= r_band3;
        for (int e = 0; e < 2; e++) begin
            r_phi4[e] <= w_phi[e];
            r_den4[e] <= D_W'(w_phi[e]) - D_W'(w_plo[e]);
            r_qlo4[e] <= w_qlo[e];
            r_qhi4[e] <= w_qhi[e];
        end
    end

    // stage 5: clamp numerator, load divider
    logic                     r_v5;
    logic [BAND_W-1:0]        r_band5;
    t_div                     r_d5 [2];
    logic [P_W-1:0]           w_num [2];

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            if (r_phi4[e] < 0) begin
                w_num[e] = '0;
            end else if (D_W'(r_phi4[e]) > r_den4[e]) begin
                w_num[e] = r_den4[e][P_W-1:0];
            end else begin
                w_num[e] = r_phi4[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_band5 <= r_band4;
        for (int e = 0; e < 2; e++) begin
            r_d5[e].deg <= r_den4[e] <= 0;
            r_d5[e].rem <= {1'b0, w_num[e], 17'd0} + R_W'(r_den4[e][P_W-1:0]);
            r_d5[e].dvs <= r_den4[e][P_W-1:0];
            r_d5[e].quo <= '0;
            r_d5[e].qlo <= r_qlo4[e];
            r_d5[e].qhi <= r_qhi4[e];
        end
    end

    // divider: one quotient bit per stage, most significant first
    logic                     r_dv_v    [DIV_N];
    logic [BAND_W-1:0]        r_dv_band [DIV_N];
    t_div                     r_dv      [DIV_N][2];

    for (genvar j = 0; j < DIV_N; j++) begin : g_div
        localparam int K = DIV_N - 1 - j;
        t_div             w_in [2];
        t_div             w_nx [2];
        logic             w_vin;
        logic [BAND_W-1:0] w_bin;
        logic [R_W-1:0]   w_sh [2];

        always_comb begin
            if (j == 0) begin
                w_vin = r_v5;
                w_bin = r_band5;
                w_in  = r_d5;
            end else begin
                w_vin = r_dv_v[(j == 0) ? 0 : j-1];
                w_bin = r_dv_band[(j == 0) ? 0 : j-1];
                w_in  = r_dv[(j == 0) ? 0 : j-1];
            end
            // subtract the shifted divisor where it fits
            for (int e = 0; e < 2; e++) begin
                w_sh[e] = R_W'({w_in[e].dvs, 1'b0}) << K;
                w_nx[e] = w_in[e];
                if (w_in[e].rem >= w_sh[e]) begin
                    w_nx[e].rem    = w_in[e].rem - w_sh[e];
                    w_nx[e].quo[K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else begin
                r_dv_v[j] <= w_vin;
            end
            r_dv_band[j] <= w_bin;
            for (int e = 0; e < 2; e++) begin
                r_dv[j][e] <= w_nx[e];
            end
        end
    end

    // stage 6: weight the two positions of each edge
    logic                     r_v6;
    logic [BAND_W-1:0]        r_band6;
    logic signed [M_W-1:0]    r_mlo6 [2][3];
    logic signed [M_W-1:0]    r_mhi6 [2][3];
    logic [Q_W-1:0]           w_wlo [2];
    logic [Q_W-1:0]           w_whi [2];

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            w_wlo[e] = r_dv[DIV_N-1][e].deg ? Q_W'(32768) : r_dv[DIV_N-1][e].quo;
            w_whi[e] = Q_W'(65536) - w_wlo[e];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_dv_v[DIV_N-1];
        end
        r_band6 <= r_dv_band[DIV_N-1];
        for (int e = 0; e < 2; e++) begin
            for (int k = 0; k < 3; k++) begin
                r_mlo6[e][k] <= $signed(r_dv[DIV_N-1][e].qlo[COMP_W*k +: COMP_W])
                              * $signed({1'b0, w_wlo[e]});
                r_mhi6[e][k] <= $signed(r_dv[DIV_N-1][e].qhi[COMP_W*k +: COMP_W])
                              * $signed({1'b0, w_whi[e]});
            end
        end
    end

    // stage 7: sum, round half up, drive result
    logic                     r_strobe;
    t_out_item                r_out;
    logic signed [M_W:0]      w_sum [2][3];
    logic [VEC_W-1:0]         w_end [2];

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            for (int k = 0; k < 3; k++) begin
                w_sum[e][k] = (M_W+1)'(r_mlo6[e][k]) + (M_W+1)'(r_mhi6[e][k])
                            + (M_W+1)'(32768);
                w_end[e][COMP_W*k +: COMP_W] = w_sum[e][k][COMP_W +: COMP_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v6;
        end
        r_out.out_band   <= r_band6;
        r_out.end_first  <= w_end[0];
        r_out.end_second <= w_end[1];
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_out;

    // each segment traces back to an earlier start
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("segment without matching triangle");

    // weight never exceeds one
    a_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[DIV_N-1] && !r_dv[DIV_N-1][0].deg) |->
            r_dv[DIV_N-1][0].quo <= Q_W'(65536))
        else $error("edge weight above one");

    // divider leaves a remainder below the doubled divisor
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[DIV_N-1] && !r_dv[DIV_N-1][1].deg) |->
            r_dv[DIV_N-1][1].rem < R_W'({r_dv[DIV_N-1][1].dvs, 1'b0}))
        else $error("divider remainder out of range");

endmodule
